/* hw/rtl/rgpd_pkg.sv */
// Package for the retro graphics pixel decoder.
// Holds the mode codes, register indexes, widths, constants and the configuration struct.
// It has no dependencies.
package rgpd_pkg;

	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 12;
	localparam int DIM_BITS       = 12;
	localparam int PIX_BITS       = 8;
	localparam int NUM_PIX        = 8;
	localparam int COUNT_BITS     = 4;
	localparam int LINEAR_BITS    = 24;
	localparam int OUT_INDEX_BITS = 24;
	localparam int INDEX_BITS_DEF = 24;
	localparam int CELL_COL_BITS  = 9;
	localparam int SPRITE_DIM_BITS = 8;
	localparam int IN_DATA_BITS   = 24;
	localparam int OUT_DATA_BITS  = 96;

	localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd320;
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd200;

	// Reciprocal constants: x / 3 for x below 2048 and x / 21 for x below 4096.
	localparam int DIV3_MUL    = 683;
	localparam int DIV3_SHIFT  = 11;
	localparam int DIV21_MUL   = 3121;
	localparam int DIV21_SHIFT = 16;

	localparam logic [4:0] CELL_LAST_ROW   = 5'd7;
	localparam logic [4:0] CELL_ROWS       = 5'd8;
	localparam logic [4:0] SPRITE_LAST_ROW = 5'd20;
	localparam logic [4:0] SPRITE_PAD_ROW  = 5'd21;
	localparam logic [1:0] SPRITE_LAST_BYTE = 2'd2;

	localparam logic [COUNT_BITS-1:0] COUNT_FULL = 4'd8;
	localparam logic [COUNT_BITS-1:0] COUNT_WIDE = 4'd2;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE  = 4'd1;

	localparam logic [CFG_IDX_BITS-1:0] REG_MODE       = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BACKGROUND = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MC_ZERO    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_MC_ONE     = 3'd5;

	typedef enum logic [2:0] {
		MODE_BITMAP       = 3'd0,
		MODE_MC_BITMAP    = 3'd1,
		MODE_SPRITE       = 3'd2,
		MODE_MC_SPRITE    = 3'd3,
		MODE_CHAR         = 3'd4,
		MODE_MC_CHAR      = 3'd5,
		MODE_UNRESTRICTED = 3'd6,
		MODE_WIDE         = 3'd7
	} mode_t;

	typedef struct packed {
		mode_t                      mode;
		logic [DIM_BITS-1:0]        width;
		logic [PIX_BITS-1:0]        background;
		logic [PIX_BITS-1:0]        mc_zero;
		logic [PIX_BITS-1:0]        mc_one;
		logic [CELL_COL_BITS-1:0]   cell_cols;
		logic [CELL_COL_BITS-1:0]   cell_rows;
		logic [SPRITE_DIM_BITS-1:0] sprite_cols;
		logic [SPRITE_DIM_BITS-1:0] sprite_rows;
		logic [LINEAR_BITS-1:0]     pixel_total;
	} cfg_t;

	typedef logic [3:0][PIX_BITS-1:0]       palette_t;
	typedef logic [NUM_PIX-1:0][PIX_BITS-1:0] pix_group_t;

endpackage

/* hw/rtl/rgpd_cfg.sv */
// Configuration registers of the pixel decoder and the image geometry derived from them.
// Depends on rgpd_pkg for register indexes, reset values and the cfg_t struct.
module rgpd_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                write,
	input  logic [rgpd_pkg::CFG_IDX_BITS-1:0]   index,
	input  logic [rgpd_pkg::CFG_DATA_BITS-1:0]  data,
	output rgpd_pkg::cfg_t                      cfg
);

	rgpd_pkg::mode_t                         mode_q;
	logic [rgpd_pkg::DIM_BITS-1:0]           width_q;
	logic [rgpd_pkg::DIM_BITS-1:0]           height_q;
	logic [rgpd_pkg::PIX_BITS-1:0]           background_q;
	logic [rgpd_pkg::PIX_BITS-1:0]           mc_zero_q;
	logic [rgpd_pkg::PIX_BITS-1:0]           mc_one_q;
	logic [rgpd_pkg::CELL_COL_BITS-1:0]      cell_cols_q;
	logic [rgpd_pkg::CELL_COL_BITS-1:0]      cell_rows_q;
	logic [rgpd_pkg::SPRITE_DIM_BITS-1:0]    sprite_cols_q;
	logic [rgpd_pkg::SPRITE_DIM_BITS-1:0]    sprite_rows_q;
	logic [rgpd_pkg::LINEAR_BITS-1:0]        pixel_total_q;
	logic [19:0]                             div3_prod;
	logic [23:0]                             div21_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= rgpd_pkg::MODE_BITMAP;
			width_q      <= rgpd_pkg::WIDTH_RESET;
			height_q     <= rgpd_pkg::HEIGHT_RESET;
			background_q <= '0;
			mc_zero_q    <= '0;
			mc_one_q     <= '0;
		end else if (write) begin
			case (index)
				rgpd_pkg::REG_MODE:       mode_q       <= rgpd_pkg::mode_t'(data[2:0]);
				rgpd_pkg::REG_WIDTH:      width_q      <= data;
				rgpd_pkg::REG_HEIGHT:     height_q     <= data;
				rgpd_pkg::REG_BACKGROUND: background_q <= data[rgpd_pkg::PIX_BITS-1:0];
				rgpd_pkg::REG_MC_ZERO:    mc_zero_q    <= data[rgpd_pkg::PIX_BITS-1:0];
				rgpd_pkg::REG_MC_ONE:     mc_one_q     <= data[rgpd_pkg::PIX_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sprites are 24 pixels wide: width / 24 is (width / 8) / 3.
	assign div3_prod  = 20'(width_q[11:3]) * 20'(rgpd_pkg::DIV3_MUL);
	assign div21_prod = 24'(height_q) * 24'(rgpd_pkg::DIV21_MUL);

	always_ff @(posedge clk) begin
		cell_cols_q   <= width_q[11:3];
		cell_rows_q   <= height_q[11:3];
		sprite_cols_q <= 8'(div3_prod >> rgpd_pkg::DIV3_SHIFT);
		sprite_rows_q <= 8'(div21_prod >> rgpd_pkg::DIV21_SHIFT);
		pixel_total_q <= 24'(width_q) * 24'(height_q);
	end

	always_comb begin
		cfg.mode        = mode_q;
		cfg.width       = width_q;
		cfg.background  = background_q;
		cfg.mc_zero     = mc_zero_q;
		cfg.mc_one      = mc_one_q;
		cfg.cell_cols   = cell_cols_q;
		cfg.cell_rows   = cell_rows_q;
		cfg.sprite_cols = sprite_cols_q;
		cfg.sprite_rows = sprite_rows_q;
		cfg.pixel_total = pixel_total_q;
	end

endmodule

/* hw/rtl/rgpd_expand.sv */
// Expands one graphics byte into eight color indices through a four-entry palette.
// Depends on rgpd_pkg for the palette and pixel group types.
module rgpd_expand (
	input  logic [rgpd_pkg::PIX_BITS-1:0] pattern,
	input  logic                          multi,
	input  rgpd_pkg::palette_t            palette,
	output rgpd_pkg::pix_group_t          pix
);

	logic [1:0] sel [rgpd_pkg::NUM_PIX];

	// Multicolor reads bit pairs from the top, each pair covering two pixels.
	always_comb begin
		for (int x = 0; x < rgpd_pkg::NUM_PIX; x++) begin
			if (multi) begin
				sel[x] = 2'(pattern >> (6 - 2 * (x / 2)));
			end else begin
				sel[x] = {1'b0, pattern[7 - x]};
			end
			pix[x] = palette[sel[x]];
		end
	end

endmodule

/* hw/rtl/retro_graphics_pixel_decode_top.sv */
// Retro graphics pixel decoder: graphics bytes in, groups of up to eight color indices out.
// An accepted item is held in the input register and then decoded into the result register that drives the output.
// Throughput is one item per cycle while the output is not held off, set by the input register and the result register.
// The asynchronous reset clears the counters and the handshake state and loads the
// register reset values; no clearing pass follows, items are accepted right after reset.
// Depends on rgpd_pkg, rgpd_cfg and rgpd_expand.
module retro_graphics_pixel_decode_top #(
	parameter int INDEX_BITS = rgpd_pkg::INDEX_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [rgpd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [rgpd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// Fields from bit 0: pattern_byte[7:0], screen_byte[15:8], color_byte[23:16].
	input  logic [rgpd_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// Fields from bit 0: restart[0].
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// Fields from bit 0: pix0..pix7[63:0], pixel_index[87:64], pixel_count[91:88], zero[95:92].
	output logic [rgpd_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	output logic                                 m_tlast
);

	rgpd_pkg::cfg_t cfg;

	logic                                 valid_s1;
	logic [rgpd_pkg::PIX_BITS-1:0]        pattern_s1;
	logic [rgpd_pkg::PIX_BITS-1:0]        screen_s1;
	logic [rgpd_pkg::PIX_BITS-1:0]        color_s1;
	logic                                 restart_s1;

	logic [rgpd_pkg::DIM_BITS-1:0]        cell_column_q;
	logic [rgpd_pkg::DIM_BITS-1:0]        cell_row_q;
	logic [4:0]                           row_in_cell_q;
	logic [1:0]                           byte_in_row_q;
	logic [rgpd_pkg::LINEAR_BITS-1:0]     linear_count_q;

	logic                                 valid_s2;
	rgpd_pkg::pix_group_t                 pix_s2;
	logic [rgpd_pkg::OUT_INDEX_BITS-1:0]  index_s2;
	logic [rgpd_pkg::COUNT_BITS-1:0]      count_s2;
	logic                                 last_s2;

	logic                                 advance;
	logic                                 emit;
	logic                                 multi;
	logic                                 linear;
	logic [rgpd_pkg::DIM_BITS-1:0]        col;
	logic [rgpd_pkg::DIM_BITS-1:0]        row;
	logic [4:0]                           ric;
	logic [1:0]                           bir;
	logic [rgpd_pkg::LINEAR_BITS-1:0]     lc;
	logic [rgpd_pkg::DIM_BITS-1:0]        col_next;
	logic [rgpd_pkg::DIM_BITS-1:0]        row_next;
	logic [4:0]                           ric_next;
	logic [1:0]                           bir_next;
	logic [rgpd_pkg::LINEAR_BITS-1:0]     lc_next;
	logic [rgpd_pkg::COUNT_BITS-1:0]      count;
	logic                                 last;
	logic [16:0]                          lines;
	logic [16:0]                          col_off;
	rgpd_pkg::palette_t                   palette;
	rgpd_pkg::pix_group_t                 exp_pix;
	rgpd_pkg::pix_group_t                 pix;
	logic [INDEX_BITS-1:0]                index_calc;
	logic [31:0]                          index_wide;

	rgpd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.write  (cfg_write),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	rgpd_expand u_expand (
		.pattern (pattern_s1),
		.multi   (multi),
		.palette (palette),
		.pix     (exp_pix)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign multi = (cfg.mode == rgpd_pkg::MODE_MC_BITMAP) ||
		(cfg.mode == rgpd_pkg::MODE_MC_SPRITE) || (cfg.mode == rgpd_pkg::MODE_MC_CHAR);

	// A restart clears the counters before the byte is taken.
	assign col = restart_s1 ? '0 : cell_column_q;
	assign row = restart_s1 ? '0 : cell_row_q;
	assign ric = restart_s1 ? '0 : row_in_cell_q;
	assign bir = restart_s1 ? '0 : byte_in_row_q;
	assign lc  = restart_s1 ? '0 : linear_count_q;

	always_comb begin
		emit      = 1'b0;
		linear    = 1'b0;
		col_next  = col;
		row_next  = row;
		ric_next  = ric;
		bir_next  = bir;
		lc_next   = lc;
		count     = rgpd_pkg::COUNT_FULL;
		last      = 1'b0;
		lines     = '0;
		col_off   = '0;
		palette   = '0;
		case (cfg.mode)
			rgpd_pkg::MODE_UNRESTRICTED, rgpd_pkg::MODE_WIDE: begin
				linear = 1'b1;
				if (lc < cfg.pixel_total) begin
					emit = 1'b1;
					if (cfg.mode == rgpd_pkg::MODE_WIDE && (cfg.pixel_total - lc) >= 24'd2) begin
						count = rgpd_pkg::COUNT_WIDE;
					end else begin
						count = rgpd_pkg::COUNT_ONE;
					end
					lc_next = lc + 24'(count);
					last    = lc_next >= cfg.pixel_total;
				end
			end
			rgpd_pkg::MODE_SPRITE, rgpd_pkg::MODE_MC_SPRITE: begin
				palette[0] = cfg.background;
				palette[1] = multi ? cfg.mc_zero : color_s1;
				palette[2] = multi ? color_s1 : '0;
				palette[3] = cfg.mc_one;
				lines   = 17'(row) * 17'(rgpd_pkg::SPRITE_PAD_ROW) + 17'(ric);
				col_off = 17'(col) * 17'd24 + 17'({bir, 3'b000});
				if (col < 12'(cfg.sprite_cols) && row < 12'(cfg.sprite_rows) &&
					ric <= rgpd_pkg::SPRITE_PAD_ROW && bir <= rgpd_pkg::SPRITE_LAST_BYTE) begin
					if (ric == rgpd_pkg::SPRITE_PAD_ROW) begin
						ric_next = '0;
						bir_next = '0;
						if ((13'(col) + 13'd1) >= 13'(cfg.sprite_cols)) begin
							col_next = '0;
							row_next = row + 12'd1;
						end else begin
							col_next = col + 12'd1;
						end
					end else begin
						emit = 1'b1;
						last = (13'(col) + 13'd1) == 13'(cfg.sprite_cols) &&
							(13'(row) + 13'd1) == 13'(cfg.sprite_rows) &&
							ric == rgpd_pkg::SPRITE_LAST_ROW && bir == rgpd_pkg::SPRITE_LAST_BYTE;
						if (bir == rgpd_pkg::SPRITE_LAST_BYTE) begin
							bir_next = '0;
							ric_next = ric + 5'd1;
						end else begin
							bir_next = bir + 2'd1;
						end
					end
				end
			end
			default: begin
				palette[0] = cfg.background;
				palette[1] = color_s1;
				palette[2] = cfg.mc_zero;
				palette[3] = cfg.mc_one;
				case (cfg.mode)
					rgpd_pkg::MODE_BITMAP: begin
						palette[0] = {4'h0, screen_s1[3:0]};
						palette[1] = {4'h0, screen_s1[7:4]};
					end
					rgpd_pkg::MODE_MC_BITMAP: begin
						palette[1] = {4'h0, screen_s1[7:4]};
						palette[2] = {4'h0, screen_s1[3:0]};
						palette[3] = {4'h0, color_s1[3:0]};
					end
					rgpd_pkg::MODE_CHAR: begin
						palette[1] = {4'h0, color_s1[3:0]};
					end
					default: begin
						palette[1] = cfg.mc_zero;
						palette[2] = cfg.mc_one;
						palette[3] = {4'h0, color_s1[3:0]};
					end
				endcase
				lines   = 17'({row, 3'b000}) + 17'(ric);
				col_off = 17'({col, 3'b000});
				if (col < 12'(cfg.cell_cols) && row < 12'(cfg.cell_rows) &&
					ric <= rgpd_pkg::CELL_LAST_ROW) begin
					emit = 1'b1;
					last = (13'(col) + 13'd1) == 13'(cfg.cell_cols) &&
						(13'(row) + 13'd1) == 13'(cfg.cell_rows) &&
						ric == rgpd_pkg::CELL_LAST_ROW;
					if ((ric + 5'd1) == rgpd_pkg::CELL_ROWS) begin
						ric_next = '0;
						if ((13'(col) + 13'd1) >= 13'(cfg.cell_cols)) begin
							col_next = '0;
							row_next = row + 12'd1;
						end else begin
							col_next = col + 12'd1;
						end
					end else begin
						ric_next = ric + 5'd1;
					end
				end
			end
		endcase
	end

	always_comb begin
		if (linear) begin
			pix    = '0;
			pix[0] = pattern_s1;
			if (count == rgpd_pkg::COUNT_WIDE) begin
				pix[1] = pattern_s1;
			end
			index_calc = INDEX_BITS'(lc);
		end else begin
			pix        = exp_pix;
			index_calc = INDEX_BITS'(lines) * INDEX_BITS'(cfg.width) + INDEX_BITS'(col_off);
		end
		index_wide = 32'(index_calc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pattern_s1 <= s_tdata[7:0];
			screen_s1  <= s_tdata[15:8];
			color_s1   <= s_tdata[23:16];
			restart_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_column_q  <= '0;
			cell_row_q     <= '0;
			row_in_cell_q  <= '0;
			byte_in_row_q  <= '0;
			linear_count_q <= '0;
		end else if (advance) begin
			cell_column_q  <= col_next;
			cell_row_q     <= row_next;
			row_in_cell_q  <= ric_next;
			byte_in_row_q  <= bir_next;
			linear_count_q <= lc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			pix_s2   <= pix;
			index_s2 <= index_wide[rgpd_pkg::OUT_INDEX_BITS-1:0];
			count_s2 <= count;
			last_s2  <= last;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {4'h0, count_s2, index_s2, pix_s2};

`ifndef NO_ASSERTIONS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled while the result register is empty");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> valid_s2)
		else $error("decoded item did not reach the result register");

	a_result_drained: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && m_tready && !(advance && emit) |=> !valid_s2)
		else $error("delivered item was presented again");

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (count_s2 == rgpd_pkg::COUNT_FULL || count_s2 == rgpd_pkg::COUNT_WIDE ||
			count_s2 == rgpd_pkg::COUNT_ONE))
		else $error("pixel count out of range");
`endif

endmodule

/* bench/retro_graphics_pixel_decode_top_tb.sv */
// Self-checking bench for retro_graphics_pixel_decode_top: directed and random byte streams in all
// eight graphics modes, each result checked against a decoder model kept inside the bench.
// Depends on rgpd_pkg and the decoder RTL.
module retro_graphics_pixel_decode_top_tb;

	localparam int HOLD_CYCLES     = 80;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 6;
	localparam int MAX_IMAGE_ITEMS = 160;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		logic                                                 last;
		logic [rgpd_pkg::COUNT_BITS-1:0]                      count;
		logic [rgpd_pkg::OUT_INDEX_BITS-1:0]                  index;
		logic [rgpd_pkg::NUM_PIX-1:0][rgpd_pkg::PIX_BITS-1:0] pix;
	} decoded_group_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_write = 1'b0;
	logic [rgpd_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [rgpd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                               s_tvalid = 1'b0;
	logic                               s_tready;
	logic [rgpd_pkg::IN_DATA_BITS-1:0]  s_tdata = '0;
	logic                               s_tuser = 1'b0;
	logic                               m_tvalid;
	logic                               m_tready = 1'b0;
	logic [rgpd_pkg::OUT_DATA_BITS-1:0] m_tdata;
	logic                               m_tlast;

	rgpd_pkg::mode_t dec_mode = rgpd_pkg::MODE_BITMAP;
	logic [11:0]   dec_width = rgpd_pkg::WIDTH_RESET;
	logic [11:0]   dec_height = rgpd_pkg::HEIGHT_RESET;
	logic [7:0]    dec_background = '0;
	logic [7:0]    dec_mc_zero = '0;
	logic [7:0]    dec_mc_one = '0;
	logic [11:0]   walk_col = '0;
	logic [11:0]   walk_row = '0;
	logic [4:0]    walk_line = '0;
	logic [1:0]    walk_byte = '0;
	logic [23:0]   walk_linear = '0;

	decoded_group_t expected_groups[$];
	int  items_sent = 0;
	int  results_checked = 0;
	int  mismatch_count = 0;
	int  quiet_cycles = 0;
	int  send_idle_pct = 8;
	int  recv_idle_pct = 58;
	int  hold_left = 0;
	bit  hold_request = 1'b0;
	bit [7:0] modes_covered = '0;

	retro_graphics_pixel_decode_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit decode_byte(input logic [7:0] pb, input logic [7:0] sv,
			input logic [7:0] cv, input logic restart, output decoded_group_t grp);
		int unsigned w, h, n, sw, sh, cw, ch, idx;
		int x;
		rgpd_pkg::palette_t cmap;
		logic [1:0] sel;
		bit multi;
		w = dec_width;
		h = dec_height;
		grp = '0;
		grp.count = rgpd_pkg::COUNT_FULL;
		multi = (dec_mode == rgpd_pkg::MODE_MC_BITMAP || dec_mode == rgpd_pkg::MODE_MC_SPRITE ||
			dec_mode == rgpd_pkg::MODE_MC_CHAR);
		if (restart) begin
			walk_col = '0;
			walk_row = '0;
			walk_line = '0;
			walk_byte = '0;
			walk_linear = '0;
		end
		if (dec_mode == rgpd_pkg::MODE_UNRESTRICTED || dec_mode == rgpd_pkg::MODE_WIDE) begin
			n = w * h;
			if (walk_linear >= n)
				return 1'b0;
			if (dec_mode == rgpd_pkg::MODE_WIDE && n - walk_linear >= 2)
				grp.count = rgpd_pkg::COUNT_WIDE;
			else
				grp.count = rgpd_pkg::COUNT_ONE;
			grp.index = walk_linear;
			grp.pix[0] = pb;
			if (grp.count == rgpd_pkg::COUNT_WIDE)
				grp.pix[1] = pb;
			walk_linear = walk_linear + grp.count;
			grp.last = (walk_linear >= n);
			return 1'b1;
		end
		if (dec_mode == rgpd_pkg::MODE_SPRITE || dec_mode == rgpd_pkg::MODE_MC_SPRITE) begin
			sw = w / 24;
			sh = h / 21;
			if (walk_col >= sw || walk_row >= sh || walk_line > rgpd_pkg::SPRITE_PAD_ROW ||
					walk_byte > rgpd_pkg::SPRITE_LAST_BYTE)
				return 1'b0;
			// The padding byte closes the sprite without producing pixels.
			if (walk_line == rgpd_pkg::SPRITE_PAD_ROW) begin
				walk_line = '0;
				walk_byte = '0;
				walk_col++;
				if (walk_col >= sw) begin
					walk_col = '0;
					walk_row++;
				end
				return 1'b0;
			end
			cmap[0] = dec_background;
			cmap[1] = multi ? dec_mc_zero : cv;
			cmap[2] = multi ? cv : 8'h00;
			cmap[3] = dec_mc_one;
			idx = (walk_row * 21 + walk_line) * w + walk_col * 24 + walk_byte * 8;
			grp.last = (walk_col == sw - 1 && walk_row == sh - 1 &&
				walk_line == rgpd_pkg::SPRITE_LAST_ROW &&
				walk_byte == rgpd_pkg::SPRITE_LAST_BYTE);
			walk_byte++;
			if (walk_byte == 2'd3) begin
				walk_byte = '0;
				walk_line++;
			end
		end else begin
			cw = w >> 3;
			ch = h >> 3;
			if (walk_col >= cw || walk_row >= ch || walk_line > rgpd_pkg::CELL_LAST_ROW)
				return 1'b0;
			cmap[0] = dec_background;
			cmap[1] = cv;
			cmap[2] = dec_mc_zero;
			cmap[3] = dec_mc_one;
			case (dec_mode)
				rgpd_pkg::MODE_BITMAP: begin
					cmap[0] = {4'h0, sv[3:0]};
					cmap[1] = {4'h0, sv[7:4]};
				end
				rgpd_pkg::MODE_MC_BITMAP: begin
					cmap[1] = {4'h0, sv[7:4]};
					cmap[2] = {4'h0, sv[3:0]};
					cmap[3] = {4'h0, cv[3:0]};
				end
				rgpd_pkg::MODE_CHAR: begin
					cmap[1] = {4'h0, cv[3:0]};
				end
				default: begin
					cmap[1] = dec_mc_zero;
					cmap[2] = dec_mc_one;
					cmap[3] = {4'h0, cv[3:0]};
				end
			endcase
			idx = (walk_row * 8 + walk_line) * w + walk_col * 8;
			grp.last = (walk_col == cw - 1 && walk_row == ch - 1 &&
				walk_line == rgpd_pkg::CELL_LAST_ROW);
			walk_line++;
			if (walk_line == rgpd_pkg::CELL_ROWS) begin
				walk_line = '0;
				walk_col++;
				if (walk_col >= cw) begin
					walk_col = '0;
					walk_row++;
				end
			end
		end
		for (x = 0; x < rgpd_pkg::NUM_PIX; x++) begin
			if (multi)
				sel = 2'((pb >> (6 - 2 * (x >> 1))) & 8'd3);
			else
				sel = 2'((pb >> (7 - x)) & 8'd1);
			grp.pix[x] = cmap[sel];
		end
		grp.index = rgpd_pkg::OUT_INDEX_BITS'(idx);
		return 1'b1;
	endfunction

	function automatic logic [7:0] some_byte();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	task automatic send_byte(input logic [7:0] pb, input logic [7:0] sv, input logic [7:0] cv,
			input logic restart);
		decoded_group_t grp;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {cv, sv, pb};
		s_tuser <= restart;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		if (decode_byte(pb, sv, cv, restart, grp)) begin
			expected_groups.push_back(grp);
			modes_covered[dec_mode] = 1'b1;
		end
		@(negedge clk);
	endtask

	// Lets the pipeline empty, including items that produce no result.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_groups.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_config(input rgpd_pkg::mode_t m, input logic [11:0] w,
			input logic [11:0] h, input logic [7:0] bg, input logic [7:0] mc0,
			input logic [7:0] mc1);
		logic [rgpd_pkg::CFG_DATA_BITS-1:0] values [6];
		int i;
		settle();
		values[rgpd_pkg::REG_MODE] = {9'd0, m};
		values[rgpd_pkg::REG_WIDTH] = w;
		values[rgpd_pkg::REG_HEIGHT] = h;
		values[rgpd_pkg::REG_BACKGROUND] = {4'd0, bg};
		values[rgpd_pkg::REG_MC_ZERO] = {4'd0, mc0};
		values[rgpd_pkg::REG_MC_ONE] = {4'd0, mc1};
		for (i = rgpd_pkg::REG_MODE; i <= rgpd_pkg::REG_MC_ONE; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= rgpd_pkg::CFG_IDX_BITS'(i);
			cfg_data <= values[i];
			@(posedge clk);
			case (rgpd_pkg::CFG_IDX_BITS'(i))
				rgpd_pkg::REG_MODE:       dec_mode = rgpd_pkg::mode_t'(values[i][2:0]);
				rgpd_pkg::REG_WIDTH:      dec_width = values[i];
				rgpd_pkg::REG_HEIGHT:     dec_height = values[i];
				rgpd_pkg::REG_BACKGROUND: dec_background = values[i][7:0];
				rgpd_pkg::REG_MC_ZERO:    dec_mc_zero = values[i][7:0];
				rgpd_pkg::REG_MC_ONE:     dec_mc_one = values[i][7:0];
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	task automatic test_reset_values();
		send_byte(8'h00, 8'hF0, 8'h00, 1'b1);
		send_byte(8'hFF, 8'h0F, 8'hFF, 1'b0);
	endtask

	task automatic test_multicolor_maps();
		apply_config(rgpd_pkg::MODE_MC_BITMAP, 12'd16, 12'd8, 8'h00, 8'hFF, 8'h5A);
		send_byte(8'h1B, 8'h5A, 8'hFF, 1'b1);
		apply_config(rgpd_pkg::MODE_MC_CHAR, 12'd16, 12'd8, 8'hFF, 8'h00, 8'hA5);
		send_byte(8'hE4, 8'h00, 8'h3C, 1'b1);
	endtask

	task automatic test_sprite_maps();
		apply_config(rgpd_pkg::MODE_SPRITE, 12'd24, 12'd21, 8'h00, 8'h11, 8'h22);
		send_byte(8'h81, 8'h00, 8'hFF, 1'b1);
		apply_config(rgpd_pkg::MODE_MC_SPRITE, 12'd48, 12'd42, 8'hFF, 8'h11, 8'h22);
		send_byte(8'h1B, 8'hFF, 8'h80, 1'b1);
	endtask

	// Three-pixel images: the wide mode ends on a single pixel, and a byte after the
	// image is complete produces nothing.
	task automatic test_linear_modes();
		apply_config(rgpd_pkg::MODE_UNRESTRICTED, 12'd3, 12'd1, 8'h00, 8'h00, 8'h00);
		send_byte(8'hFF, 8'h00, 8'h00, 1'b1);
		send_byte(8'h00, 8'hFF, 8'hFF, 1'b0);
		send_byte(8'h80, 8'h00, 8'h00, 1'b0);
		send_byte(8'h7F, 8'h00, 8'h00, 1'b0);
		apply_config(rgpd_pkg::MODE_WIDE, 12'd3, 12'd1, 8'h00, 8'h00, 8'h00);
		send_byte(8'h01, 8'h00, 8'h00, 1'b1);
		send_byte(8'hFE, 8'h00, 8'h00, 1'b0);
		send_byte(8'h55, 8'h00, 8'h00, 1'b0);
	endtask

	task automatic test_empty_images();
		apply_config(rgpd_pkg::MODE_BITMAP, 12'd7, 12'd8, 8'h00, 8'h00, 8'h00);
		send_byte(8'hFF, 8'hFF, 8'hFF, 1'b1);
		apply_config(rgpd_pkg::MODE_WIDE, 12'd4095, 12'd0, 8'hFF, 8'hFF, 8'hFF);
		send_byte(8'hFF, 8'hFF, 8'hFF, 1'b1);
	endtask

	// Shrinking the image below the current cell row stops output until a restart.
	task automatic test_counter_range();
		int k;
		apply_config(rgpd_pkg::MODE_CHAR, 12'd8, 12'd16, 8'h0F, 8'h00, 8'h00);
		for (k = 0; k < 8; k++)
			send_byte(8'($urandom), 8'($urandom), 8'($urandom), k == 0);
		apply_config(rgpd_pkg::MODE_CHAR, 12'd8, 12'd8, 8'h0F, 8'h00, 8'h00);
		send_byte(8'hC3, 8'h00, 8'h0A, 1'b0);
		send_byte(8'hC3, 8'h00, 8'h0A, 1'b1);
	endtask

	task automatic test_random_images(input int target);
		rgpd_pkg::mode_t m;
		int unsigned w, h, len, k, pick;
		logic [7:0] bg, mc0, mc1;
		bit restart_first;
		int start_count;
		start_count = items_sent;
		while (items_sent - start_count < target) begin
			m = rgpd_pkg::mode_t'($urandom_range(7));
			case (m)
				rgpd_pkg::MODE_SPRITE, rgpd_pkg::MODE_MC_SPRITE: begin
					w = 24 * $urandom_range(1, 2);
					h = 21 * $urandom_range(1, 2);
					len = (w / 24) * (h / 21) * 64;
				end
				rgpd_pkg::MODE_UNRESTRICTED, rgpd_pkg::MODE_WIDE: begin
					w = $urandom_range(1, 12);
					h = $urandom_range(1, 6);
					len = (m == rgpd_pkg::MODE_WIDE) ? (w * h + 1) / 2 : w * h;
				end
				default: begin
					w = 8 * $urandom_range(1, 4);
					h = 8 * $urandom_range(1, 2);
					len = (w / 8) * (h / 8) * 8;
				end
			endcase
			pick = $urandom_range(99);
			if (pick < 10) begin
				w += $urandom_range(0, 23);
				h += $urandom_range(0, 20);
			end else if (pick < 13) begin
				w = 4095;
				h = 4095;
				len = MAX_IMAGE_ITEMS;
			end else if (pick < 16) begin
				if ($urandom_range(1))
					w = 0;
				else
					h = 0;
				len = 4;
			end
			if (len > MAX_IMAGE_ITEMS)
				len = MAX_IMAGE_ITEMS;
			len += $urandom_range(0, 3);
			bg = some_byte();
			mc0 = some_byte();
			mc1 = some_byte();
			restart_first = ($urandom_range(99) >= 10);
			apply_config(m, 12'(w), 12'(h), bg, mc0, mc1);
			for (k = 0; k < len && items_sent - start_count < target; k++)
				send_byte(some_byte(), some_byte(), some_byte(),
					(k == 0 && restart_first) || $urandom_range(99) == 0);
		end
	endtask

	// The output is held off while items keep coming, so the input side must stall.
	task automatic test_backpressure();
		int k;
		apply_config(rgpd_pkg::MODE_UNRESTRICTED, 12'd4095, 12'd4095, 8'h00, 8'h00, 8'h00);
		hold_request = 1'b1;
		for (k = 0; k < 48; k++)
			send_byte(8'($urandom), 8'($urandom), 8'($urandom), k == 0);
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		decoded_group_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tlast, m_tdata[$bits(decoded_group_t)-2:0]};
			if (expected_groups.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("Unexpected result: index %0d count %0d last %b pix %h",
						got.index, got.count, got.last, got.pix);
			end else begin
				want = expected_groups.pop_front();
				results_checked++;
				if (got.pix != want.pix || got.index != want.index ||
						got.count != want.count || got.last != want.last ||
						m_tdata[rgpd_pkg::OUT_DATA_BITS-1:$bits(decoded_group_t)-1] != '0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("Mismatch on result %0d: expected index %0d count %0d last %b pix %h",
							results_checked, want.index, want.count, want.last, want.pix);
						$display("  got index %0d count %0d last %b pix %h pad %h",
							got.index, got.count, got.last, got.pix,
							m_tdata[rgpd_pkg::OUT_DATA_BITS-1:$bits(decoded_group_t)-1]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("retro_graphics_pixel_decode_top test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_values();
		test_multicolor_maps();
		test_sprite_maps();
		test_linear_modes();
		test_empty_images();
		test_counter_range();
		test_random_images(400);
		send_idle_pct = 58;
		recv_idle_pct = 8;
		test_random_images(400);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_images(400);
		settle();
		$display("Sent %0d items and checked %0d pixel groups; modes with output: %b",
			items_sent, results_checked, modes_covered);
		$display("Covered map corners, sprite padding, image ends, empty images and a long stall.");
		if (mismatch_count == 0 && expected_groups.size() == 0)
			$display("retro_graphics_pixel_decode_top test passed");
		else
			$display("retro_graphics_pixel_decode_top test failed");
		$finish;
	end

endmodule
